// ===== src/min_cost_assignment_solver_assert.svh =====
// Assertion macros shared by the assignment solver modules.
// Each macro expects the including module to have i_clk and i_rst_n.
`ifndef MIN_COST_ASSIGNMENT_SOLVER_ASSERT_SVH
`define MIN_COST_ASSIGNMENT_SOLVER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCAS_CHECK_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MCAS_CHECK_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/mcas_pkg.sv =====
// Shared types and constants for the minimum-cost assignment solver.
// Used by the controller, the datapath and the top level.
package mcas_pkg;

    localparam int MAX_SIZE_DEF  = 16;
    localparam int COST_BITS_DEF = 16;
    localparam int COST_IN_BITS  = 16;
    localparam int MSIZE_BITS    = 5;
    localparam int LABEL_BITS    = 4;
    localparam int TOTAL_BITS    = 20;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    localparam logic [MSIZE_BITS-1:0] MSIZE_RESET     = 5'd16;
    localparam logic                  REG_MATRIX_SIZE = 1'b0;

    typedef enum logic [4:0] {
        OP_LOAD,
        OP_RMIN_RD,
        OP_RMIN_EX,
        OP_RSUB_RD,
        OP_RSUB_EX,
        OP_CMIN_RD,
        OP_CMIN_EX,
        OP_CSUB_RD,
        OP_CSUB_EX,
        OP_GRD_RD,
        OP_GRD_EX,
        OP_ROUND,
        OP_SEED,
        OP_POP,
        OP_SRCH_RD,
        OP_SRCH_EX,
        OP_AUG,
        OP_AMIN_RD,
        OP_AMIN_EX,
        OP_ADJ_RD,
        OP_ADJ_EX,
        OP_SUM_RD,
        OP_SUM_EX,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_fire;
        logic emit_fire;
    } t_cmd;

    typedef struct packed {
        logic last_i;
        logic last_j;
        logic grd_hit;
        logic q_empty;
        logic srch_free;
        logic aug_stop;
        logic keep_going;
        logic found_any;
    } t_stat;

endpackage

// ===== src/mcas_ctrl.sv =====
// Sequencing state machine of the assignment solver.
// Depends on mcas_pkg and the shared assertion macros.
`include "min_cost_assignment_solver_assert.svh"

module mcas_ctrl
    import mcas_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    input  logic  i_cost_valid,
    input  logic  i_result_ready,
    output t_cmd  o_cmd,
    output logic  o_cost_ready,
    output logic  o_result_valid
);

    typedef enum logic [23:0] {
        S_LOAD    = 24'h000001,
        S_RMIN_RD = 24'h000002,
        S_RMIN_EX = 24'h000004,
        S_RSUB_RD = 24'h000008,
        S_RSUB_EX = 24'h000010,
        S_CMIN_RD = 24'h000020,
        S_CMIN_EX = 24'h000040,
        S_CSUB_RD = 24'h000080,
        S_CSUB_EX = 24'h000100,
        S_GRD_RD  = 24'h000200,
        S_GRD_EX  = 24'h000400,
        S_ROUND   = 24'h000800,
        S_SEED    = 24'h001000,
        S_POP     = 24'h002000,
        S_SRCH_RD = 24'h004000,
        S_SRCH_EX = 24'h008000,
        S_AUG     = 24'h010000,
        S_AMIN_RD = 24'h020000,
        S_AMIN_EX = 24'h040000,
        S_ADJ_RD  = 24'h080000,
        S_ADJ_EX  = 24'h100000,
        S_SUM_RD  = 24'h200000,
        S_SUM_EX  = 24'h400000,
        S_EMIT    = 24'h800000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_op    op;
    logic   load_fire;
    logic   emit_fire;
    logic   last_ij;

    assign o_cost_ready   = (r_state == S_LOAD);
    assign o_result_valid = (r_state == S_EMIT);
    assign load_fire      = o_cost_ready && i_cost_valid;
    assign emit_fire      = o_result_valid && i_result_ready;
    assign last_ij        = i_stat.last_i && i_stat.last_j;

    always_comb begin
        n_state = r_state;
        op      = OP_LOAD;
        case (r_state)
            S_LOAD: begin
                op = OP_LOAD;
                if (load_fire && last_ij) n_state = S_RMIN_RD;
            end
            S_RMIN_RD: begin
                op = OP_RMIN_RD;
                n_state = S_RMIN_EX;
            end
            S_RMIN_EX: begin
                op = OP_RMIN_EX;
                n_state = i_stat.last_j ? S_RSUB_RD : S_RMIN_RD;
            end
            S_RSUB_RD: begin
                op = OP_RSUB_RD;
                n_state = S_RSUB_EX;
            end
            S_RSUB_EX: begin
                op = OP_RSUB_EX;
                if (!i_stat.last_j) n_state = S_RSUB_RD;
                else n_state = i_stat.last_i ? S_CMIN_RD : S_RMIN_RD;
            end
            S_CMIN_RD: begin
                op = OP_CMIN_RD;
                n_state = S_CMIN_EX;
            end
            S_CMIN_EX: begin
                op = OP_CMIN_EX;
                n_state = i_stat.last_i ? S_CSUB_RD : S_CMIN_RD;
            end
            S_CSUB_RD: begin
                op = OP_CSUB_RD;
                n_state = S_CSUB_EX;
            end
            S_CSUB_EX: begin
                op = OP_CSUB_EX;
                if (!i_stat.last_i) n_state = S_CSUB_RD;
                else n_state = i_stat.last_j ? S_GRD_RD : S_CMIN_RD;
            end
            S_GRD_RD: begin
                op = OP_GRD_RD;
                n_state = S_GRD_EX;
            end
            S_GRD_EX: begin
                op = OP_GRD_EX;
                if ((i_stat.grd_hit || i_stat.last_j) && i_stat.last_i) n_state = S_ROUND;
                else n_state = S_GRD_RD;
            end
            S_ROUND: begin
                op = OP_ROUND;
                n_state = i_stat.keep_going ? S_SEED : S_SUM_RD;
            end
            S_SEED: begin
                op = OP_SEED;
                if (i_stat.last_i) n_state = S_POP;
            end
            S_POP: begin
                op = OP_POP;
                n_state = i_stat.q_empty ? S_AMIN_RD : S_SRCH_RD;
            end
            S_SRCH_RD: begin
                op = OP_SRCH_RD;
                n_state = S_SRCH_EX;
            end
            S_SRCH_EX: begin
                op = OP_SRCH_EX;
                if (i_stat.srch_free) n_state = S_AUG;
                else n_state = i_stat.last_j ? S_POP : S_SRCH_RD;
            end
            S_AUG: begin
                op = OP_AUG;
                if (i_stat.aug_stop) n_state = S_ROUND;
            end
            S_AMIN_RD: begin
                op = OP_AMIN_RD;
                n_state = S_AMIN_EX;
            end
            S_AMIN_EX: begin
                op = OP_AMIN_EX;
                if (!last_ij) n_state = S_AMIN_RD;
                else n_state = i_stat.found_any ? S_ADJ_RD : S_SUM_RD;
            end
            S_ADJ_RD: begin
                op = OP_ADJ_RD;
                n_state = S_ADJ_EX;
            end
            S_ADJ_EX: begin
                op = OP_ADJ_EX;
                n_state = last_ij ? S_ROUND : S_ADJ_RD;
            end
            S_SUM_RD: begin
                op = OP_SUM_RD;
                n_state = S_SUM_EX;
            end
            S_SUM_EX: begin
                op = OP_SUM_EX;
                n_state = i_stat.last_i ? S_EMIT : S_SUM_RD;
            end
            S_EMIT: begin
                op = OP_EMIT;
                if (emit_fire && i_stat.last_i) n_state = S_LOAD;
            end
            default: begin
                op = OP_LOAD;
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.op        = op;
    assign o_cmd.load_fire = load_fire;
    assign o_cmd.emit_fire = emit_fire;

    `MCAS_CHECK_NEXT(a_load_starts_solve, load_fire && last_ij, r_state == S_RMIN_RD, "full matrix did not start the solve")
    `MCAS_CHECK_NEXT(a_last_word_reloads, emit_fire && i_stat.last_i, r_state == S_LOAD, "last result word did not return to loading")
    `MCAS_CHECK_NEXT(a_aug_holds, r_state == S_AUG && !i_stat.aug_stop, r_state == S_AUG, "augmentation left before its end")

endmodule

// ===== src/mcas_dpath.sv =====
// Datapath of the assignment solver: cost memories, matching, labels and queue.
// Depends on mcas_pkg and the shared assertion macros.
`include "min_cost_assignment_solver_assert.svh"

module mcas_dpath
    import mcas_pkg::*;
#(
    parameter int MAX_SIZE  = MAX_SIZE_DEF,
    parameter int COST_BITS = COST_BITS_DEF
)(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  t_cmd                             i_cmd,
    input  logic                             i_cfg_wr,
    input  logic [$clog2(MAX_SIZE+1)-1:0]    i_size,
    input  logic [COST_IN_BITS-1:0]          i_cost_value,
    output t_stat                            o_stat,
    output logic [LABEL_BITS-1:0]            o_row_index,
    output logic [LABEL_BITS-1:0]            o_assigned_column,
    output logic [TOTAL_BITS-1:0]            o_total_cost,
    output logic                             o_last_row
);

    localparam int IDXW     = $clog2(MAX_SIZE);
    localparam int NW       = $clog2(MAX_SIZE + 1);
    localparam int RED_BITS = COST_BITS + 8;
    localparam int DEPTH    = 1 << (2 * IDXW);
    localparam int PW       = 2 * (NW + 1);
    localparam int RW       = $clog2((MAX_SIZE + 2) * (MAX_SIZE + 2) + 1);

    logic [COST_BITS-1:0] r_orig_mem [DEPTH];
    logic [RED_BITS-1:0]  r_red_mem  [DEPTH];
    logic [COST_BITS-1:0] r_orig_rd;
    logic [RED_BITS-1:0]  r_red_rd;

    logic [IDXW-1:0]     r_i;
    logic [IDXW-1:0]     r_j;
    logic [IDXW-1:0]     r_r;
    logic [IDXW-1:0]     r_aj;
    logic [NW-1:0]       r_guard;
    logic [NW-1:0]       r_head;
    logic [NW-1:0]       r_tail;
    logic [NW-1:0]       r_matched;
    logic [RW-1:0]       r_rounds;
    logic [RED_BITS-1:0] r_lo;
    logic                r_found;
    logic [TOTAL_BITS-1:0] r_total;

    logic            r_rm_v   [MAX_SIZE];
    logic [IDXW-1:0] r_rm     [MAX_SIZE];
    logic            r_cm_v   [MAX_SIZE];
    logic [IDXW-1:0] r_cm     [MAX_SIZE];
    logic            r_rp_v   [MAX_SIZE];
    logic            r_rp_root[MAX_SIZE];
    logic [IDXW-1:0] r_rp     [MAX_SIZE];
    logic            r_cp_v   [MAX_SIZE];
    logic [IDXW-1:0] r_cp     [MAX_SIZE];
    logic [IDXW-1:0] r_q      [MAX_SIZE];

    logic                  last_i;
    logic                  last_j;
    logic [RED_BITS-1:0]   d_orig;
    logic [RED_BITS-1:0]   d_red;
    logic                  grd_hit;
    logic                  edge_ok;
    logic                  srch_free;
    logic [IDXW-1:0]       k_row;
    logic [IDXW-1:0]       aug_row;
    logic                  aug_stop;
    logic                  q_empty;
    logic                  amin_cand;
    logic [IDXW-1:0]       sum_col;
    logic [NW:0]           n_plus2;
    logic [PW-1:0]         lim_full;
    logic                  keep_going;
    logic                  row_lab;
    logic                  col_lab;
    logic                  orig_we;
    logic                  red_we;
    logic [COST_BITS-1:0]  orig_wdata;
    logic [RED_BITS-1:0]   red_wdata;
    logic [2*IDXW-1:0]     raddr;
    logic [2*IDXW-1:0]     waddr;

    assign last_i   = (NW'(r_i) == NW'(i_size - 1'b1));
    assign last_j   = (NW'(r_j) == NW'(i_size - 1'b1));
    assign d_orig   = RED_BITS'(r_orig_rd);
    assign d_red    = r_red_rd;
    assign grd_hit  = (d_red == '0) && !r_cm_v[r_j];
    assign edge_ok  = (d_red == '0) && !r_cp_v[r_j] && !(r_rm_v[r_r] && (r_rm[r_r] == r_j));
    assign srch_free = edge_ok && !r_cm_v[r_j];
    assign k_row    = r_cm[r_j];
    assign aug_row  = r_cp[r_aj];
    assign aug_stop = r_rp_root[aug_row] || !r_rp_v[aug_row] || (r_guard == NW'(MAX_SIZE));
    assign q_empty  = (r_head >= r_tail);
    assign amin_cand = r_rp_v[r_i] && !r_cp_v[r_j] && (!r_found || (d_red < r_lo));
    assign sum_col  = r_rm_v[r_i] ? r_rm[r_i] : '0;
    assign n_plus2  = (NW + 1)'(i_size) + (NW + 1)'(2);
    assign lim_full = PW'(n_plus2) * PW'(n_plus2);
    assign keep_going = (r_matched < i_size) && (PW'(r_rounds) < lim_full);
    assign row_lab  = r_rp_v[r_i];
    assign col_lab  = r_cp_v[r_j];

    assign o_stat.last_i     = last_i;
    assign o_stat.last_j     = last_j;
    assign o_stat.grd_hit    = grd_hit;
    assign o_stat.q_empty    = q_empty;
    assign o_stat.srch_free  = srch_free;
    assign o_stat.aug_stop   = aug_stop;
    assign o_stat.keep_going = keep_going;
    assign o_stat.found_any  = r_found || amin_cand;

    assign o_row_index       = LABEL_BITS'(r_i);
    assign o_assigned_column = LABEL_BITS'(sum_col);
    assign o_total_cost      = r_total;
    assign o_last_row        = last_i;

    assign orig_we    = (i_cmd.op == OP_LOAD) && i_cmd.load_fire;
    assign orig_wdata = COST_BITS'({{COST_BITS{1'b0}}, i_cost_value});
    assign waddr      = {r_i, r_j};

    always_comb begin
        red_we    = 1'b0;
        red_wdata = d_red;
        raddr     = {r_i, r_j};
        case (i_cmd.op)
            OP_RSUB_EX: begin
                red_we    = 1'b1;
                red_wdata = d_orig - r_lo;
            end
            OP_CSUB_EX: begin
                red_we    = 1'b1;
                red_wdata = d_red - r_lo;
            end
            OP_ADJ_EX: begin
                red_we = 1'b1;
                if (row_lab && !col_lab) red_wdata = d_red - r_lo;
                else if (!row_lab && col_lab) red_wdata = d_red + r_lo;
                else red_wdata = d_red;
            end
            OP_SRCH_RD: begin
                raddr = {r_r, r_j};
            end
            OP_SUM_RD: begin
                raddr = {r_i, sum_col};
            end
            default: begin
                red_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (orig_we) r_orig_mem[waddr] <= orig_wdata;
        r_orig_rd <= r_orig_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (red_we) r_red_mem[waddr] <= red_wdata;
        r_red_rd <= r_red_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i       <= '0;
            r_j       <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_matched <= '0;
            r_rounds  <= '0;
            r_found   <= 1'b0;
            r_guard   <= '0;
            for (int m = 0; m < MAX_SIZE; m++) begin
                r_rm_v[m]    <= 1'b0;
                r_cm_v[m]    <= 1'b0;
                r_rp_v[m]    <= 1'b0;
                r_rp_root[m] <= 1'b0;
                r_cp_v[m]    <= 1'b0;
            end
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (i_cmd.load_fire) begin
                        if (last_j) begin
                            r_j <= '0;
                            if (last_i) begin
                                r_i       <= '0;
                                r_matched <= '0;
                                r_rounds  <= '0;
                                r_total   <= '0;
                                for (int m = 0; m < MAX_SIZE; m++) begin
                                    r_rm_v[m] <= 1'b0;
                                    r_cm_v[m] <= 1'b0;
                                end
                            end else begin
                                r_i <= r_i + 1'b1;
                            end
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                OP_RMIN_EX: begin
                    if (r_j == '0 || d_orig < r_lo) r_lo <= d_orig;
                    r_j <= last_j ? '0 : r_j + 1'b1;
                end
                OP_RSUB_EX: begin
                    if (last_j) begin
                        r_j <= '0;
                        r_i <= last_i ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                OP_CMIN_EX: begin
                    if (r_i == '0 || d_red < r_lo) r_lo <= d_red;
                    r_i <= last_i ? '0 : r_i + 1'b1;
                end
                OP_CSUB_EX: begin
                    if (last_i) begin
                        r_i <= '0;
                        r_j <= last_j ? '0 : r_j + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                OP_GRD_EX: begin
                    if (grd_hit) begin
                        r_rm_v[r_i] <= 1'b1;
                        r_rm[r_i]   <= r_j;
                        r_cm_v[r_j] <= 1'b1;
                        r_cm[r_j]   <= r_i;
                        r_matched   <= r_matched + 1'b1;
                    end
                    if (grd_hit || last_j) begin
                        r_j <= '0;
                        r_i <= last_i ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                OP_ROUND: begin
                    r_i    <= '0;
                    r_j    <= '0;
                    r_head <= '0;
                    r_tail <= '0;
                    for (int m = 0; m < MAX_SIZE; m++) begin
                        r_rp_v[m]    <= 1'b0;
                        r_rp_root[m] <= 1'b0;
                        r_cp_v[m]    <= 1'b0;
                    end
                end
                OP_SEED: begin
                    if (!r_rm_v[r_i]) begin
                        r_rp_v[r_i]    <= 1'b1;
                        r_rp_root[r_i] <= 1'b1;
                        r_q[r_tail[IDXW-1:0]] <= r_i;
                        r_tail <= r_tail + 1'b1;
                    end
                    r_i <= last_i ? '0 : r_i + 1'b1;
                end
                OP_POP: begin
                    r_i     <= '0;
                    r_j     <= '0;
                    r_found <= 1'b0;
                    if (!q_empty) begin
                        r_r    <= r_q[r_head[IDXW-1:0]];
                        r_head <= r_head + 1'b1;
                    end
                end
                OP_SRCH_EX: begin
                    if (edge_ok) begin
                        r_cp_v[r_j] <= 1'b1;
                        r_cp[r_j]   <= r_r;
                        if (!r_cm_v[r_j]) begin
                            r_aj    <= r_j;
                            r_guard <= '0;
                        end else if (!r_rp_v[k_row] && (r_tail < NW'(MAX_SIZE))) begin
                            r_rp_v[k_row]    <= 1'b1;
                            r_rp_root[k_row] <= 1'b0;
                            r_rp[k_row]      <= r_j;
                            r_q[r_tail[IDXW-1:0]] <= k_row;
                            r_tail <= r_tail + 1'b1;
                        end
                    end
                    if (!srch_free) r_j <= last_j ? '0 : r_j + 1'b1;
                end
                OP_AUG: begin
                    r_rm_v[aug_row] <= 1'b1;
                    r_rm[aug_row]   <= r_aj;
                    r_cm_v[r_aj]    <= 1'b1;
                    r_cm[r_aj]      <= aug_row;
                    if (aug_stop) begin
                        r_matched <= r_matched + 1'b1;
                        r_rounds  <= r_rounds + 1'b1;
                    end else begin
                        r_aj    <= r_rp[aug_row];
                        r_guard <= r_guard + 1'b1;
                    end
                end
                OP_AMIN_EX: begin
                    if (amin_cand) begin
                        r_lo    <= d_red;
                        r_found <= 1'b1;
                    end
                    if (last_j) begin
                        r_j <= '0;
                        r_i <= last_i ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                OP_ADJ_EX: begin
                    if (last_j) begin
                        r_j <= '0;
                        r_i <= last_i ? '0 : r_i + 1'b1;
                        if (last_i) r_rounds <= r_rounds + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                OP_SUM_EX: begin
                    r_total <= r_total + TOTAL_BITS'(r_orig_rd);
                    r_i     <= last_i ? '0 : r_i + 1'b1;
                end
                OP_EMIT: begin
                    if (i_cmd.emit_fire) begin
                        r_i <= last_i ? '0 : r_i + 1'b1;
                        r_j <= '0;
                    end
                end
                default: begin
                    r_found <= r_found;
                end
            endcase
            if (i_cfg_wr) begin
                r_i <= '0;
                r_j <= '0;
            end
        end
    end

    `MCAS_CHECK_NOW(a_tail_bound, 1'b1, int'(r_tail) <= MAX_SIZE, "search queue overran its depth")
    `MCAS_CHECK_NOW(a_head_le_tail, 1'b1, r_head <= r_tail, "queue head passed its tail")
    `MCAS_CHECK_NOW(a_matched_bound, i_cmd.op == OP_ROUND, r_matched <= i_size, "more rows matched than the matrix has")

endmodule

// ===== src/min_cost_assignment_solver.sv =====
// Top level of the minimum-cost assignment solver with its configuration register.
// Depends on mcas_pkg, mcas_ctrl and mcas_dpath.
//
// Load n*n costs row by row, one word per cycle; the last word starts the solve and no
// word is taken until all n result words have left, one per cycle while the sink is
// ready. Every matrix entry the solver visits takes a read state and an execute state,
// because both cost memories have a single registered read port. The solve runs row
// reduction, column reduction and greedy matching, then search rounds, each seeding
// the queue and searching the rows taken from it, matrix adjustments between rounds,
// and last the final cost sum.
module min_cost_assignment_solver
    import mcas_pkg::*;
#(
    parameter int MAX_SIZE  = MAX_SIZE_DEF,
    parameter int COST_BITS = COST_BITS_DEF
)(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready,
    input  logic                     i_cost_valid,
    output logic                     o_cost_ready,
    input  logic [COST_IN_BITS-1:0]  i_cost_value,
    output logic                     o_result_valid,
    input  logic                     i_result_ready,
    output logic [LABEL_BITS-1:0]    o_row_index,
    output logic [LABEL_BITS-1:0]    o_assigned_column,
    output logic [TOTAL_BITS-1:0]    o_total_cost,
    output logic                     o_last_row
);

    localparam int NW = $clog2(MAX_SIZE + 1);

    logic [MSIZE_BITS-1:0] r_msize;
    logic                  cfg_wr;
    logic [NW-1:0]         size;
    t_cmd                  cmd;
    t_stat                 stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MATRIX_SIZE);
    assign prdata = (paddr[2] == REG_MATRIX_SIZE) ? APB_DATA_BITS'(r_msize) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msize <= MSIZE_RESET;
        end else if (cfg_wr) begin
            r_msize <= pwdata[MSIZE_BITS-1:0];
        end
    end

    always_comb begin
        if (r_msize == '0) size = NW'(1);
        else if (int'(r_msize) > MAX_SIZE) size = NW'(MAX_SIZE);
        else size = NW'(r_msize);
    end

    mcas_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_stat         (stat),
        .i_cost_valid   (i_cost_valid),
        .i_result_ready (i_result_ready),
        .o_cmd          (cmd),
        .o_cost_ready   (o_cost_ready),
        .o_result_valid (o_result_valid)
    );

    mcas_dpath #(
        .MAX_SIZE  (MAX_SIZE),
        .COST_BITS (COST_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg_wr          (cfg_wr),
        .i_size            (size),
        .i_cost_value      (i_cost_value),
        .o_stat            (stat),
        .o_row_index       (o_row_index),
        .o_assigned_column (o_assigned_column),
        .o_total_cost      (o_total_cost),
        .o_last_row        (o_last_row)
    );

endmodule

// ===== tb/sv/min_cost_assignment_solver_test.sv =====
// Testbench for min_cost_assignment_solver: loads cost matrices, predicts the optimal assignment
// with its own Hungarian solver and checks every result word against it.
// Depends on mcas_pkg and the min_cost_assignment_solver RTL only.
`timescale 1ns / 100ps

module min_cost_assignment_solver_test;
    import mcas_pkg::*;

    localparam int MAX_N   = 16;
    localparam int NO_LINK = 255;
    localparam int ROOT    = 254;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_SIZE   = 3'd0;
    localparam logic [APB_ADDR_BITS-1:0] ADDR_UNUSED = 3'd4;

    typedef struct {
        logic [LABEL_BITS-1:0] row;
        logic [LABEL_BITS-1:0] col;
        logic [TOTAL_BITS-1:0] total;
        logic                  last;
    } t_row_result;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_cost_valid;
    logic                     o_cost_ready;
    logic [COST_IN_BITS-1:0]  i_cost_value;
    logic                     o_result_valid;
    logic                     i_result_ready;
    logic [LABEL_BITS-1:0]    o_row_index;
    logic [LABEL_BITS-1:0]    o_assigned_column;
    logic [TOTAL_BITS-1:0]    o_total_cost;
    logic                     o_last_row;

    t_row_result expected_rows[$];
    int          errors;
    bit          sink_steady;
    int          sink_hold;

    // Predictor state.
    logic [4:0]  size_reg;
    int          load_cnt;
    logic [15:0] cost_store[MAX_N*MAX_N];
    longint      work_cost[MAX_N*MAX_N];
    int          row_mate[MAX_N];
    int          col_mate[MAX_N];
    int          row_from[MAX_N];
    int          col_from[MAX_N];
    int          row_fifo[MAX_N];
    int          mated;

    min_cost_assignment_solver i_dut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int size_used();
        if (size_reg < 1) return 1;
        if (size_reg > MAX_N) return MAX_N;
        return size_reg;
    endfunction

    function automatic void reduce_lines(int n);
        longint lo;
        for (int i = 0; i < n; i++) begin
            lo = work_cost[i*n];
            for (int j = 1; j < n; j++) if (work_cost[i*n+j] < lo) lo = work_cost[i*n+j];
            for (int j = 0; j < n; j++) work_cost[i*n+j] -= lo;
        end
        for (int j = 0; j < n; j++) begin
            lo = work_cost[j];
            for (int i = 1; i < n; i++) if (work_cost[i*n+j] < lo) lo = work_cost[i*n+j];
            for (int i = 0; i < n; i++) work_cost[i*n+j] -= lo;
        end
    endfunction

    function automatic void greedy_match(int n);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (work_cost[i*n+j] == 0 && col_mate[j] == NO_LINK) begin
                    row_mate[i] = j;
                    col_mate[j] = i;
                    mated++;
                    break;
                end
            end
        end
    endfunction

    function automatic void augment_path(int col);
        int j;
        int r;
        int back;
        j = col;
        for (int guard = 0; guard <= MAX_N; guard++) begin
            r = col_from[j];
            back = row_from[r];
            row_mate[r] = j;
            col_mate[j] = r;
            if (back == ROOT || back >= MAX_N) break;
            j = back;
        end
        mated++;
    endfunction

    function automatic bit find_path(int n);
        int head;
        int tail;
        int r;
        int k;
        head = 0;
        tail = 0;
        for (int i = 0; i < MAX_N; i++) begin
            row_from[i] = NO_LINK;
            col_from[i] = NO_LINK;
        end
        for (int i = 0; i < n; i++) begin
            if (row_mate[i] == NO_LINK) begin
                row_from[i] = ROOT;
                row_fifo[tail++] = i;
            end
        end
        while (head < tail) begin
            r = row_fifo[head++];
            for (int j = 0; j < n; j++) begin
                if (work_cost[r*n+j] != 0 || col_from[j] != NO_LINK) continue;
                if (row_mate[r] == j) continue;
                col_from[j] = r;
                if (col_mate[j] == NO_LINK) begin
                    augment_path(j);
                    return 1'b1;
                end
                k = col_mate[j];
                if (row_from[k] == NO_LINK && tail < MAX_N) begin
                    row_from[k] = j;
                    row_fifo[tail++] = k;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic bit adjust_uncovered(int n);
        bit     found;
        bit     rl;
        bit     cl;
        longint lo;
        found = 1'b0;
        lo = 0;
        for (int i = 0; i < n; i++) begin
            if (row_from[i] == NO_LINK) continue;
            for (int j = 0; j < n; j++) begin
                if (col_from[j] == NO_LINK && (!found || work_cost[i*n+j] < lo)) begin
                    lo = work_cost[i*n+j];
                    found = 1'b1;
                end
            end
        end
        if (!found) return 1'b0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                rl = row_from[i] != NO_LINK;
                cl = col_from[j] != NO_LINK;
                if (rl && !cl) work_cost[i*n+j] -= lo;
                else if (!rl && cl) work_cost[i*n+j] += lo;
            end
        end
        return 1'b1;
    endfunction

    function automatic void solve_assignment(int n);
        t_row_result res;
        longint      total;
        int          c;
        for (int i = 0; i < MAX_N; i++) begin
            row_mate[i] = NO_LINK;
            col_mate[i] = NO_LINK;
        end
        mated = 0;
        for (int i = 0; i < n*n; i++) work_cost[i] = cost_store[i];
        reduce_lines(n);
        greedy_match(n);
        for (int rounds = 0; mated < n && rounds < (n+2)*(n+2); rounds++) begin
            if (find_path(n)) continue;
            if (!adjust_uncovered(n)) break;
        end
        total = 0;
        for (int i = 0; i < n; i++) begin
            c = row_mate[i] < n ? row_mate[i] : 0;
            total += cost_store[i*n+c];
        end
        for (int i = 0; i < n; i++) begin
            c = row_mate[i] < n ? row_mate[i] : 0;
            res.row   = i[LABEL_BITS-1:0];
            res.col   = c[LABEL_BITS-1:0];
            res.total = total[TOTAL_BITS-1:0];
            res.last  = (i + 1 == n);
            expected_rows.push_back(res);
        end
    endfunction

    function automatic void accept_cost(logic [COST_IN_BITS-1:0] v);
        int n;
        n = size_used();
        if (load_cnt >= n*n) load_cnt = 0;
        cost_store[load_cnt] = v;
        load_cnt++;
        if (load_cnt < n*n) return;
        load_cnt = 0;
        solve_assignment(n);
    endfunction

    task automatic send_cost(logic [COST_IN_BITS-1:0] v);
        repeat (pick_gap()) begin
            i_cost_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_cost_valid <= 1'b1;
        i_cost_value <= v;
        do @(posedge i_clk); while (!o_cost_ready);
        accept_cost(v);
    endtask

    task automatic end_burst();
        i_cost_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        end_burst();
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_ADDR_BITS-1:0] addr, logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_SIZE) begin
            size_reg = data[4:0];
            load_cnt = 0;
        end
    endtask

    task automatic load_matrix(int n, int mode);
        for (int k = 0; k < n*n; k++) begin
            case (mode)
                0: send_cost(COST_IN_BITS'($urandom_range(0, 3)));
                1: send_cost(COST_IN_BITS'($urandom_range(0, 65535)));
                2: send_cost(COST_IN_BITS'(32'hFFFF - $urandom_range(0, 2)));
                default: send_cost(COST_IN_BITS'($urandom_range(0, 40)));
            endcase
        end
        wait_idle();
    endtask

    task automatic test_full_size_at_reset();
        load_matrix(MAX_N, 1);
    endtask

    task automatic test_size_one_and_clamp();
        apb_write(ADDR_SIZE, 32'd0);
        send_cost(16'h0000);
        send_cost(16'hFFFF);
        wait_idle();
        apb_write(ADDR_SIZE, 32'hFFFF_FFE1);
        send_cost(16'h1234);
        wait_idle();
    endtask

    task automatic test_partial_load_discard();
        apb_write(ADDR_SIZE, 32'd31);
        send_cost(16'h5555);
        send_cost(16'hAAAA);
        send_cost(16'hFFFF);
        wait_idle();
        apb_write(ADDR_SIZE, 32'd2);
        load_matrix(2, 1);
    endtask

    task automatic test_unused_register();
        apb_write(ADDR_UNUSED, 32'd5);
        load_matrix(2, 3);
    endtask

    task automatic test_ties_and_extremes();
        apb_write(ADDR_SIZE, 32'd3);
        for (int k = 0; k < 9; k++) send_cost(16'h0000);
        wait_idle();
        load_matrix(3, 2);
        apb_write(ADDR_SIZE, 32'd16);
        send_cost(16'h0001);
        wait_idle();
    endtask

    task automatic test_random_problems();
        int sent;
        int n;
        sent = 0;
        while (sent < 200) begin
            sink_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 9) == 0) begin
                apb_write(ADDR_SIZE, $urandom_range(1, 31));
                repeat ($urandom_range(1, 3)) send_cost(COST_IN_BITS'($urandom));
                wait_idle();
            end
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
            if ($urandom_range(0, 15) == 0) apb_write(ADDR_SIZE, 32'd0);
            else apb_write(ADDR_SIZE, n);
            n = size_used();
            load_matrix(n, $urandom_range(0, 3));
            sent += n*n;
        end
        sink_steady = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_result_ready <= 1'b0;
            sink_hold <= 0;
        end else if (sink_hold > 0 && !sink_steady) begin
            i_result_ready <= 1'b0;
            sink_hold <= sink_hold - 1;
        end else begin
            i_result_ready <= 1'b1;
            sink_hold <= ($urandom_range(0, 9) < 3) ? pick_gap() : 0;
        end
    end

    always @(posedge i_clk) begin
        t_row_result want;
        if (i_rst_n && o_result_valid && i_result_ready) begin
            if (expected_rows.size() == 0) begin
                $error("unexpected result word: row %0d", o_row_index);
                errors++;
            end else begin
                want = expected_rows.pop_front();
                if (o_row_index !== want.row) begin
                    $error("row_index: expected %0d, got %0d", want.row, o_row_index);
                    errors++;
                end
                if (o_assigned_column !== want.col) begin
                    $error("assigned_column: expected %0d, got %0d", want.col,
                           o_assigned_column);
                    errors++;
                end
                if (o_total_cost !== want.total) begin
                    $error("total_cost: expected %0d, got %0d", want.total, o_total_cost);
                    errors++;
                end
                if (o_last_row !== want.last) begin
                    $error("last_row: expected %0d, got %0d", want.last, o_last_row);
                    errors++;
                end
            end
        end
    end

    initial begin
        #100_000_000;
        $display("min_cost_assignment_solver_test: errors");
        $finish;
    end

    initial begin
        errors       = 0;
        sink_steady  = 1'b0;
        size_reg     = MSIZE_RESET;
        load_cnt     = 0;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_cost_valid <= 1'b0;
        i_cost_value <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_full_size_at_reset();
        test_size_one_and_clamp();
        test_partial_load_discard();
        test_unused_register();
        test_ties_and_extremes();
        test_random_problems();
        if (errors == 0) begin
            $display("min_cost_assignment_solver_test: clean");
        end else begin
            $display("min_cost_assignment_solver_test: errors");
        end
        $finish;
    end

endmodule

// ===== min_cost_assignment_solver.f =====
+incdir+src
src/mcas_pkg.sv
src/mcas_ctrl.sv
src/mcas_dpath.sv
src/min_cost_assignment_solver.sv
tb/sv/min_cost_assignment_solver_test.sv
